/* hw/rtl/cmd_pkg.sv */
// Shared types and constants for the chunked message deframer.
// No dependencies; imported by chunked_message_deframer.
`default_nettype none

package cmd_pkg;

  localparam int unsigned LEN_W  = 15;
  localparam int unsigned BYTE_W = 8;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 15'h7FFF;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_END   = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERSIZE = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_INVALID  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef struct packed {
    status_t           status;
    logic              message_end;
    logic [BYTE_W-1:0] data;
    logic              data_valid;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/chunked_message_deframer.sv */
// Chunked message deframer on cmd_pkg: header parse, payload pass-through, errors.
// Each accepted beat's result is registered in the output buffer before out_*.
// One beat per cycle while in_tready is high; parser state updates on accept.
// A two-entry output buffer (result register plus skid) keeps in_tready high
// while one finished result waits. rst_n is synchronous and active low; it
// empties the buffer, sets the limit to 32767 and returns to awaiting a header.
`default_nettype none

module chunked_message_deframer (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Input beats.
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,   // [7:0] wire_byte
  input  wire logic [1:0]                 in_tuser,   // [1:0] command
  // Result beats.
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] data
  output logic [2:0]                      out_tuser,  // [0] data_valid, [2:1] status
  output logic                            out_tlast,  // message_end
  // Limit register write.
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [cmd_pkg::LEN_W-1:0]  cfg_data
);

  import cmd_pkg::*;

  logic [LEN_W-1:0]  max_len_r;

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] hdr_high_r, hdr_high_nxt;
  logic [LEN_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic              final_r, final_nxt;
  logic              active_r, active_nxt;
  logic              invalid_r, invalid_nxt;
  logic              discard_r, discard_nxt;

  result_t           out_r, skid_r, res;
  logic              out_v_r, skid_v_r;

  logic              accept, out_take;
  cmd_t              cmd;
  logic [BYTE_W-1:0] wbyte;
  logic [LEN_W-1:0]  pkt_len, bl_dec;
  logic              pkt_fin, oversize;

  assign cmd       = cmd_t'(in_tuser);
  assign wbyte     = in_tdata;
  assign in_tready = ~skid_v_r;
  assign accept    = in_tvalid & in_tready;
  assign out_take  = out_v_r & out_tready;
  assign cfg_ready = 1'b1;

  assign pkt_len  = {hdr_high_r[BYTE_W-2:0], wbyte};
  assign pkt_fin  = hdr_high_r[BYTE_W-1];
  assign oversize = pkt_len > max_len_r;
  assign bl_dec   = bytes_left_r - 1'b1;

  // Parser next state.
  always_comb begin
    phase_nxt      = phase_r;
    hdr_high_nxt   = hdr_high_r;
    bytes_left_nxt = bytes_left_r;
    final_nxt      = final_r;
    active_nxt     = active_r;
    invalid_nxt    = invalid_r;
    discard_nxt    = discard_r;
    unique case (cmd)
      CMD_END, CMD_CLOSE: begin
        // While invalid, ending a message drops it outright; a close also
        // clears the invalid flag whether or not a message was open.
        if (invalid_r && (active_r || cmd == CMD_CLOSE)) begin
          active_nxt     = 1'b0;
          final_nxt      = 1'b0;
          discard_nxt    = 1'b0;
          phase_nxt      = PH_HIGH;
          bytes_left_nxt = '0;
          if (cmd == CMD_CLOSE) begin
            invalid_nxt = 1'b0;
          end
        end else if (active_r && !invalid_r) begin
          discard_nxt = 1'b1;
        end
      end
      CMD_BYTE: begin
        if (!invalid_r) begin
          unique case (phase_r)
            PH_HIGH: begin
              hdr_high_nxt = wbyte;
              active_nxt   = 1'b1;
              phase_nxt    = PH_LOW;
            end
            PH_LOW: begin
              active_nxt = 1'b1;
              phase_nxt  = PH_HIGH;
              if (oversize) begin
                invalid_nxt    = 1'b1;
                bytes_left_nxt = '0;
              end else if (pkt_len == '0) begin
                if (pkt_fin) begin
                  active_nxt  = 1'b0;
                  final_nxt   = 1'b0;
                  discard_nxt = 1'b0;
                end else begin
                  invalid_nxt = 1'b1;
                end
                bytes_left_nxt = '0;
              end else begin
                bytes_left_nxt = pkt_len;
                final_nxt      = pkt_fin;
                phase_nxt      = PH_DATA;
              end
            end
            PH_DATA: begin
              bytes_left_nxt = bl_dec;
              if (bl_dec == '0) begin
                phase_nxt = PH_HIGH;
                if (final_r) begin
                  active_nxt  = 1'b0;
                  final_nxt   = 1'b0;
                  discard_nxt = 1'b0;
                end
              end
            end
            default: begin
              phase_nxt = PH_HIGH;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Result for the current beat.
  always_comb begin
    res = '{status: ST_OK, message_end: 1'b0, data: '0, data_valid: 1'b0};
    unique case (cmd)
      CMD_END: begin
        if (invalid_r) begin
          res.status = ST_INVALID;
        end
      end
      CMD_BYTE: begin
        if (invalid_r) begin
          res.status = ST_INVALID;
        end else begin
          unique case (phase_r)
            PH_LOW: begin
              if (oversize) begin
                res.status = ST_OVERSIZE;
              end else if (pkt_len == '0) begin
                if (!pkt_fin) begin
                  res.status = ST_EMPTY;
                end else begin
                  res.message_end = ~discard_r;
                end
              end
            end
            PH_DATA: begin
              if (!discard_r) begin
                res.data_valid  = 1'b1;
                res.data        = wbyte;
                res.message_end = (bl_dec == '0) && final_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= MAX_LEN_RESET;
      phase_r      <= PH_HIGH;
      hdr_high_r   <= '0;
      bytes_left_r <= '0;
      final_r      <= 1'b0;
      active_r     <= 1'b0;
      invalid_r    <= 1'b0;
      discard_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_data;
      end
      if (accept) begin
        phase_r      <= phase_nxt;
        hdr_high_r   <= hdr_high_nxt;
        bytes_left_r <= bytes_left_nxt;
        final_r      <= final_nxt;
        active_r     <= active_nxt;
        invalid_r    <= invalid_nxt;
        discard_r    <= discard_nxt;
      end
    end
  end

  // Output register with a skid entry; a new beat lands in the skid only
  // when the result register is still held by the consumer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        if (out_take) begin
          out_r    <= skid_r;
          skid_v_r <= 1'b0;
        end
      end else if (accept) begin
        if (!out_v_r || out_take) begin
          out_r   <= res;
          out_v_r <= 1'b1;
        end else begin
          skid_r   <= res;
          skid_v_r <= 1'b1;
        end
      end else if (out_take) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.data;
  assign out_tuser  = {out_r.status, out_r.data_valid};
  assign out_tlast  = out_r.message_end;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry holds a beat while the result register is empty");

  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_r.data_valid || out_r.message_end)) |-> (out_r.status == ST_OK))
    else $error("payload or message end delivered with an error status");

  a_invalid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    invalid_r |-> (phase_r == PH_HIGH && bytes_left_r == '0))
    else $error("parser not parked at a header while the stream is invalid");

  a_discard_active: assert property (@(posedge clk) disable iff (!rst_n)
    discard_r |-> active_r)
    else $error("discarding with no message open");

endmodule

`default_nettype wire
